// File: rtl/ptd_pkg.sv
package ptd_pkg;

    // Field widths of the stream and configuration ports.
    localparam int S_TDATA_W  = 8;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Widths of the registers and of the task fields.
    localparam int MAP_COUNT_W = 7;
    localparam int RED_COUNT_W = 5;
    localparam int TIMEOUT_W   = 8;
    localparam int INDEX_W     = 7;
    localparam int LETTER_W    = 7;
    localparam int TIME_W      = 32;

    // Largest map count that the register can express.
    localparam int MAP_COUNT_MAX = 2 ** MAP_COUNT_W - 1;

    // Opcodes carried in the low bits of the input tuser.
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ASK    = 2'd1;
    localparam logic [1:0] OP_SUBMIT = 2'd2;

    // Task kinds of a submit.
    localparam logic TASK_MAP    = 1'b0;
    localparam logic TASK_REDUCE = 1'b1;

    // Grant kinds of a result.
    localparam logic [1:0] GRANT_NONE   = 2'd0;
    localparam logic [1:0] GRANT_MAP    = 2'd1;
    localparam logic [1:0] GRANT_REDUCE = 2'd2;

    // Index that names the merge task, and the empty grant index.
    localparam logic [INDEX_W-1:0] MERGE_INDEX = 7'h7F;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd2;

    // Register values after reset.
    localparam logic [MAP_COUNT_W-1:0] MAP_COUNT_RESET = 7'd0;
    localparam logic [RED_COUNT_W-1:0] RED_COUNT_RESET = 5'd1;
    localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET   = 8'd10;

    // The alphabet that the reduce tasks split between them.
    localparam logic [LETTER_W-1:0] LETTER_COUNT = 7'd26;
    localparam logic [LETTER_W-1:0] FIRST_LETTER = 7'd97;
    localparam logic [LETTER_W-1:0] LAST_LETTER  = 7'd122;

    // Letter range of one reduce task.
    typedef struct packed {
        logic [LETTER_W-1:0] start_code;
        logic [LETTER_W-1:0] end_code;
    } t_range;

    // Letters per reduce task for a given reduce count (alphabet size over count).
    function automatic logic [RED_COUNT_W-1:0] ptd_letter_span(
        input logic [RED_COUNT_W-1:0] count
    );
        logic [RED_COUNT_W-1:0] span;
        case (count)
            5'd1:    span = 5'd26;
            5'd2:    span = 5'd13;
            5'd3:    span = 5'd8;
            5'd4:    span = 5'd6;
            5'd5:    span = 5'd5;
            5'd6:    span = 5'd4;
            5'd7:    span = 5'd3;
            5'd8:    span = 5'd3;
            5'd9:    span = 5'd2;
            5'd10:   span = 5'd2;
            5'd11:   span = 5'd2;
            5'd12:   span = 5'd2;
            5'd13:   span = 5'd2;
            default: span = 5'd1;
        endcase
        return span;
    endfunction

endpackage

// File: rtl/ptd_time_mem.sv
module ptd_time_mem #(
    parameter int DEPTH = 91,
    parameter int AW    = 7
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [ptd_pkg::TIME_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [ptd_pkg::TIME_W-1:0] o_rdata
);
    import ptd_pkg::*;

    logic [TIME_W-1:0] r_mem [DEPTH];
    logic [TIME_W-1:0] r_rdata;

    // Start times are stored when a task is granted.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port for the timeout scan.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ptd_age_unit.sv
module ptd_age_unit (
    input  logic [ptd_pkg::TIME_W-1:0]    i_now,
    input  logic [ptd_pkg::TIME_W-1:0]    i_start,
    input  logic [ptd_pkg::TIMEOUT_W-1:0] i_timeout,
    output logic                          o_over
);
    import ptd_pkg::*;

    logic [TIME_W-1:0] age;

    // Age wraps with the seconds counter; a task is stale once its age exceeds the limit.
    assign age    = i_now - i_start;
    assign o_over = age > {{(TIME_W - TIMEOUT_W){1'b0}}, i_timeout};

endmodule

// File: rtl/ptd_range_unit.sv
module ptd_range_unit (
    input  logic                            i_clk,
    input  logic [ptd_pkg::RED_COUNT_W-1:0] i_count,
    input  logic [ptd_pkg::RED_COUNT_W-1:0] i_index,
    output ptd_pkg::t_range                 o_range
);
    import ptd_pkg::*;

    logic [RED_COUNT_W-1:0]   span;
    logic [2*RED_COUNT_W-1:0] offset;
    logic [LETTER_W-1:0]      span_ext;
    logic                     is_last;
    t_range                   n_range;
    t_range                   r_range;

    // First letter is the base plus index times span; the last task runs to the end.
    always_comb begin
        span                = ptd_letter_span(i_count);
        span_ext            = {{(LETTER_W - RED_COUNT_W){1'b0}}, span};
        offset              = i_index * span;
        is_last             = i_index == (i_count - 5'd1);
        n_range.start_code  = FIRST_LETTER + LETTER_W'(offset);
        n_range.end_code    = is_last ? LAST_LETTER
                                      : n_range.start_code + span_ext - 7'd1;
    end

    always_ff @(posedge i_clk) begin
        r_range <= n_range;
    end

    assign o_range = r_range;

endmodule

// File: rtl/phased_task_dispatcher_with_timeout.sv
// Task dispatcher for a map/reduce job. Input transfers carry an opcode and a
// task kind in tuser and a signed task index in tdata; each one gives exactly
// one result transfer. Tick and submit return an empty grant.
// An ask walks the start-time memory one task per cycle through a single shared
// age comparator, releasing stale tasks and noting the first free map and reduce
// task, then grants; the input is not ready during that walk.
// Task flags are flip-flops cleared by reset, so no clearing pass is needed.
// Configuration must only be written while the block is idle.
module phased_task_dispatcher_with_timeout #(
    parameter int MAX_MAP_TASKS    = 64,
    parameter int MAX_REDUCE_TASKS = 26
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [6:0] task_index
    input  logic [ptd_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // [1:0] opcode, [2] task_kind
    input  logic [ptd_pkg::S_TUSER_W-1:0]  i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [6:0] grant_index, [13:7] range_start, [20:14] range_end,
    // [27:21] map_total, [28] job_done
    output logic [ptd_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // [1:0] grant_kind
    output logic [ptd_pkg::M_TUSER_W-1:0]  o_m_tuser,
    input  logic                           i_cfg_we,
    input  logic [ptd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ptd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ptd_pkg::*;

    localparam int MAP_DEPTH  = (MAX_MAP_TASKS < MAP_COUNT_MAX) ? MAX_MAP_TASKS
                                                                : MAP_COUNT_MAX;
    localparam int RED_DEPTH  = MAX_REDUCE_TASKS;
    localparam int MAP_IW     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int RED_IW     = (RED_DEPTH > 1) ? $clog2(RED_DEPTH) : 1;
    localparam int MEM_DEPTH  = MAP_DEPTH + RED_DEPTH + 1;
    localparam int AW         = $clog2(MEM_DEPTH);
    localparam logic [MAP_COUNT_W-1:0] MAP_LIMIT = MAP_COUNT_W'(MAP_DEPTH);
    localparam logic [RED_COUNT_W-1:0] RED_LIMIT = RED_COUNT_W'(RED_DEPTH);
    localparam logic [AW-1:0] RED_BASE   = AW'(MAP_DEPTH);
    localparam logic [AW-1:0] MERGE_ADDR = AW'(MAP_DEPTH + RED_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_GRANT = 3'b100
    } t_state;

    // Part of the task table that the scan is visiting.
    typedef enum logic [3:0] {
        SEG_MAP = 4'b0001,
        SEG_RED = 4'b0010,
        SEG_MRG = 4'b0100,
        SEG_END = 4'b1000
    } t_seg;

    // Configuration and time.
    logic [MAP_COUNT_W-1:0] r_map_count, n_map_count;
    logic [RED_COUNT_W-1:0] r_red_count, n_red_count;
    logic [TIMEOUT_W-1:0]   r_timeout, n_timeout;
    logic [TIME_W-1:0]      r_now, n_now;

    // Task flags.
    logic [MAP_DEPTH-1:0] r_map_asg, n_map_asg;
    logic [MAP_DEPTH-1:0] r_map_cmp, n_map_cmp;
    logic [RED_DEPTH-1:0] r_red_asg, n_red_asg;
    logic [RED_DEPTH-1:0] r_red_cmp, n_red_cmp;
    logic                 r_mrg_asg, n_mrg_asg;
    logic                 r_mrg_cmp, n_mrg_cmp;
    logic                 r_job_fin, n_job_fin;

    // Sequencer.
    t_state               r_state, n_state;
    t_seg                 r_seg, n_seg;
    logic [INDEX_W-1:0]   r_idx, n_idx;
    logic                 r_chk_valid, n_chk_valid;
    t_seg                 r_chk_seg, n_chk_seg;
    logic [INDEX_W-1:0]   r_chk_idx, n_chk_idx;

    // Scan findings.
    logic                   r_map_found, n_map_found;
    logic [INDEX_W-1:0]     r_map_sel, n_map_sel;
    logic                   r_all_maps, n_all_maps;
    logic                   r_red_found, n_red_found;
    logic [RED_COUNT_W-1:0] r_red_sel, n_red_sel;
    logic                   r_all_red, n_all_red;

    // Output register.
    logic                   r_m_valid, n_m_valid;
    logic [1:0]             r_m_kind, n_m_kind;
    logic [INDEX_W-1:0]     r_m_index, n_m_index;
    logic [LETTER_W-1:0]    r_m_rs, n_m_rs;
    logic [LETTER_W-1:0]    r_m_re, n_m_re;
    logic [MAP_COUNT_W-1:0] r_m_total, n_m_total;
    logic                   r_m_done, n_m_done;

    // Glue.
    logic                   accept;
    logic                   out_free;
    logic [1:0]             op;
    logic                   sub_kind;
    logic [INDEX_W-1:0]     sub_idx;
    logic [INDEX_W-1:0]     sub_u;
    logic [MAP_COUNT_W-1:0] act_maps;
    logic [RED_COUNT_W-1:0] act_reds;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [TIME_W-1:0]      mem_rdata;
    logic                   age_over;
    logic                   chk_asg;
    logic                   chk_cmp;
    logic                   chk_stale;
    logic [MAP_IW-1:0]      chk_mi;
    logic [RED_IW-1:0]      chk_ri;
    t_range                 red_range;

    assign op       = i_s_tuser[1:0];
    assign sub_kind = i_s_tuser[2];
    assign sub_idx  = i_s_tdata[INDEX_W-1:0];
    assign sub_u    = {1'b0, sub_idx[INDEX_W-2:0]};
    assign act_maps = (r_map_count > MAP_LIMIT) ? MAP_LIMIT : r_map_count;
    assign act_reds = (r_red_count > RED_LIMIT) ? RED_LIMIT : r_red_count;
    assign out_free = !r_m_valid || i_m_tready;
    assign accept   = i_s_tvalid && o_s_tready;
    assign chk_mi   = r_chk_idx[MAP_IW-1:0];
    assign chk_ri   = r_chk_idx[RED_IW-1:0];

    ptd_time_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_time_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_now),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ptd_age_unit u_age_unit (
        .i_now     (r_now),
        .i_start   (mem_rdata),
        .i_timeout (r_timeout),
        .o_over    (age_over)
    );

    ptd_range_unit u_range_unit (
        .i_clk   (i_clk),
        .i_count (act_reds),
        .i_index (r_red_sel),
        .o_range (red_range)
    );

    // Flags of the entry whose start time is now on the memory output.
    always_comb begin
        case (r_chk_seg)
            SEG_MAP: begin
                chk_asg = r_map_asg[chk_mi];
                chk_cmp = r_map_cmp[chk_mi];
            end
            SEG_RED: begin
                chk_asg = r_red_asg[chk_ri];
                chk_cmp = r_red_cmp[chk_ri];
            end
            SEG_MRG: begin
                chk_asg = r_mrg_asg;
                chk_cmp = r_mrg_cmp;
            end
            default: begin
                chk_asg = 1'b0;
                chk_cmp = 1'b0;
            end
        endcase
        chk_stale = chk_asg && !chk_cmp && age_over;
    end

    // Next-state logic for configuration, the sequencer, the task table and the output.
    always_comb begin
        n_map_count = r_map_count;
        n_red_count = r_red_count;
        n_timeout   = r_timeout;
        n_now       = r_now;
        n_map_asg   = r_map_asg;
        n_map_cmp   = r_map_cmp;
        n_red_asg   = r_red_asg;
        n_red_cmp   = r_red_cmp;
        n_mrg_asg   = r_mrg_asg;
        n_mrg_cmp   = r_mrg_cmp;
        n_job_fin   = r_job_fin;
        n_state     = r_state;
        n_seg       = r_seg;
        n_idx       = r_idx;
        n_chk_valid = 1'b0;
        n_chk_seg   = r_chk_seg;
        n_chk_idx   = r_chk_idx;
        n_map_found = r_map_found;
        n_map_sel   = r_map_sel;
        n_all_maps  = r_all_maps;
        n_red_found = r_red_found;
        n_red_sel   = r_red_sel;
        n_all_red   = r_all_red;
        n_m_valid   = r_m_valid && !i_m_tready;
        n_m_kind    = r_m_kind;
        n_m_index   = r_m_index;
        n_m_rs      = r_m_rs;
        n_m_re      = r_m_re;
        n_m_total   = r_m_total;
        n_m_done    = r_m_done;
        mem_we      = 1'b0;
        mem_waddr   = MERGE_ADDR;
        mem_re      = 1'b0;
        mem_raddr   = MERGE_ADDR;

        // Configuration writes.
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAP_COUNT:    n_map_count = i_cfg_data[MAP_COUNT_W-1:0];
                CFG_REDUCE_COUNT: n_red_count = i_cfg_data[RED_COUNT_W-1:0];
                CFG_TIMEOUT:      n_timeout   = i_cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end

        // Check stage: release a stale task and record what the grant needs.
        if (r_chk_valid) begin
            case (r_chk_seg)
                SEG_MAP: begin
                    if (chk_stale) begin
                        n_map_asg[chk_mi] = 1'b0;
                    end
                    if ((!chk_asg || chk_stale) && !r_map_found) begin
                        n_map_found = 1'b1;
                        n_map_sel   = r_chk_idx;
                    end
                    if (!chk_cmp) begin
                        n_all_maps = 1'b0;
                    end
                end
                SEG_RED: begin
                    if (chk_stale) begin
                        n_red_asg[chk_ri] = 1'b0;
                    end
                    if ((!chk_asg || chk_stale) && !r_red_found) begin
                        n_red_found = 1'b1;
                        n_red_sel   = r_chk_idx[RED_COUNT_W-1:0];
                    end
                    if (!chk_cmp) begin
                        n_all_red = 1'b0;
                    end
                end
                SEG_MRG: begin
                    if (chk_stale) begin
                        n_mrg_asg = 1'b0;
                    end
                end
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_TICK: begin
                            n_now = r_now + 32'd1;
                        end
                        OP_ASK: begin
                            n_state     = S_SCAN;
                            n_seg       = SEG_MAP;
                            n_idx       = '0;
                            n_map_found = 1'b0;
                            n_all_maps  = 1'b1;
                            n_red_found = 1'b0;
                            n_all_red   = 1'b1;
                        end
                        OP_SUBMIT: begin
                            if (sub_kind == TASK_MAP) begin
                                if (!sub_idx[INDEX_W-1] && sub_u < act_maps) begin
                                    n_map_cmp[sub_u[MAP_IW-1:0]] = 1'b1;
                                end
                            end else if (sub_idx == MERGE_INDEX) begin
                                if (r_mrg_asg) begin
                                    n_mrg_cmp = 1'b1;
                                    n_job_fin = 1'b1;
                                end
                            end else if (!sub_idx[INDEX_W-1]
                                         && sub_u < {2'b00, act_reds}) begin
                                n_red_cmp[sub_u[RED_IW-1:0]] = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    // Every item but an ask answers at once with an empty grant.
                    if (op != OP_ASK) begin
                        n_m_valid = 1'b1;
                        n_m_kind  = GRANT_NONE;
                        n_m_index = MERGE_INDEX;
                        n_m_rs    = '0;
                        n_m_re    = '0;
                        n_m_total = act_maps;
                        n_m_done  = n_job_fin;
                    end
                end
            end
            S_SCAN: begin
                // Issue stage: one start-time read per cycle.
                case (r_seg)
                    SEG_MAP: begin
                        if (r_idx < act_maps) begin
                            mem_re      = 1'b1;
                            mem_raddr   = AW'(r_idx);
                            n_chk_valid = 1'b1;
                            n_chk_seg   = SEG_MAP;
                            n_chk_idx   = r_idx;
                            n_idx       = r_idx + 7'd1;
                        end else begin
                            n_seg = SEG_RED;
                            n_idx = '0;
                        end
                    end
                    SEG_RED: begin
                        if (r_idx < {2'b00, act_reds}) begin
                            mem_re      = 1'b1;
                            mem_raddr   = RED_BASE + AW'(r_idx);
                            n_chk_valid = 1'b1;
                            n_chk_seg   = SEG_RED;
                            n_chk_idx   = r_idx;
                            n_idx       = r_idx + 7'd1;
                        end else begin
                            n_seg = SEG_MRG;
                        end
                    end
                    SEG_MRG: begin
                        mem_re      = 1'b1;
                        mem_raddr   = MERGE_ADDR;
                        n_chk_valid = 1'b1;
                        n_chk_seg   = SEG_MRG;
                        n_chk_idx   = '0;
                        n_seg       = SEG_END;
                    end
                    SEG_END: begin
                        if (!r_chk_valid) begin
                            n_state = S_GRANT;
                        end
                    end
                    default: begin
                        n_seg = SEG_END;
                    end
                endcase
            end
            S_GRANT: begin
                if (out_free) begin
                    n_state   = S_IDLE;
                    n_m_valid = 1'b1;
                    n_m_kind  = GRANT_NONE;
                    n_m_index = MERGE_INDEX;
                    n_m_rs    = '0;
                    n_m_re    = '0;
                    n_m_total = act_maps;
                    n_m_done  = r_job_fin;
                    if (r_map_found) begin
                        n_map_asg[r_map_sel[MAP_IW-1:0]] = 1'b1;
                        mem_we    = 1'b1;
                        mem_waddr = AW'(r_map_sel);
                        n_m_kind  = GRANT_MAP;
                        n_m_index = r_map_sel;
                    end else if (r_all_maps && r_red_found) begin
                        n_red_asg[r_red_sel[RED_IW-1:0]] = 1'b1;
                        mem_we    = 1'b1;
                        mem_waddr = RED_BASE + AW'(r_red_sel);
                        n_m_kind  = GRANT_REDUCE;
                        n_m_index = {2'b00, r_red_sel};
                        n_m_rs    = red_range.start_code;
                        n_m_re    = red_range.end_code;
                    end else if (r_all_red && !r_mrg_asg) begin
                        n_mrg_asg = 1'b1;
                        mem_we    = 1'b1;
                        mem_waddr = MERGE_ADDR;
                        n_m_kind  = GRANT_REDUCE;
                        n_m_index = MERGE_INDEX;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_count <= MAP_COUNT_RESET;
            r_red_count <= RED_COUNT_RESET;
            r_timeout   <= TIMEOUT_RESET;
            r_now       <= '0;
            r_map_asg   <= '0;
            r_map_cmp   <= '0;
            r_red_asg   <= '0;
            r_red_cmp   <= '0;
            r_mrg_asg   <= 1'b0;
            r_mrg_cmp   <= 1'b0;
            r_job_fin   <= 1'b0;
            r_state     <= S_IDLE;
            r_seg       <= SEG_END;
            r_chk_valid <= 1'b0;
            r_chk_seg   <= SEG_END;
            r_map_found <= 1'b0;
            r_all_maps  <= 1'b1;
            r_red_found <= 1'b0;
            r_all_red   <= 1'b1;
            r_m_valid   <= 1'b0;
        end else begin
            r_map_count <= n_map_count;
            r_red_count <= n_red_count;
            r_timeout   <= n_timeout;
            r_now       <= n_now;
            r_map_asg   <= n_map_asg;
            r_map_cmp   <= n_map_cmp;
            r_red_asg   <= n_red_asg;
            r_red_cmp   <= n_red_cmp;
            r_mrg_asg   <= n_mrg_asg;
            r_mrg_cmp   <= n_mrg_cmp;
            r_job_fin   <= n_job_fin;
            r_state     <= n_state;
            r_seg       <= n_seg;
            r_chk_valid <= n_chk_valid;
            r_chk_seg   <= n_chk_seg;
            r_map_found <= n_map_found;
            r_all_maps  <= n_all_maps;
            r_red_found <= n_red_found;
            r_all_red   <= n_all_red;
            r_m_valid   <= n_m_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_chk_idx <= n_chk_idx;
        r_map_sel <= n_map_sel;
        r_red_sel <= n_red_sel;
        r_m_kind  <= n_m_kind;
        r_m_index <= n_m_index;
        r_m_rs    <= n_m_rs;
        r_m_re    <= n_m_re;
        r_m_total <= n_m_total;
        r_m_done  <= n_m_done;
    end

    // Ports.
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_kind;
    assign o_m_tdata  = {3'b000, r_m_done, r_m_total, r_m_re, r_m_rs, r_m_index};

    // The scan's check stage only runs while the sequencer is scanning.
    a_chk_in_scan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_valid |-> r_state == S_SCAN)
        else $error("check stage active outside the scan");

    // A finished job keeps its merge task assigned and completed.
    a_job_merge : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_fin |-> (r_mrg_asg && r_mrg_cmp))
        else $error("job finished without a completed merge task");

    // A selected free map task lies within the active map count.
    a_map_sel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRANT && r_map_found) |-> r_map_sel < act_maps)
        else $error("map selection beyond the active count");

    // The grant cycle always leaves a result behind and returns to idle.
    a_grant_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRANT && out_free) |=> (r_state == S_IDLE && r_m_valid))
        else $error("grant did not produce a result");

endmodule
